// ----- hdl/wis_pkg.sv -----
// Types and constants shared by the weighted index selection modules.
`default_nettype none
package wis_pkg;

    localparam int INDEX_W  = 10;
    localparam int WEIGHT_W = 17;
    localparam int RANDOM_W = 32;
    localparam int SUM_W    = 27;
    localparam int COUNT_W  = 11;
    localparam int PROD_W   = RANDOM_W + SUM_W;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_DRAW = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [INDEX_W-1:0]  entry_index;
        logic [WEIGHT_W-1:0] weight;
        logic [RANDOM_W-1:0] random_word;
    } in_word_t;

    typedef struct packed {
        logic [INDEX_W-1:0] chosen_index;
        logic [SUM_W-1:0]   total_weight;
    } out_word_t;

    typedef struct packed {
        logic                kind;
        logic                load_ok;
        logic [INDEX_W-1:0]  entry_index;
        logic [WEIGHT_W-1:0] weight;
        logic [RANDOM_W-1:0] random_word;
    } q_item_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SWEEP,
        B_MULT,
        B_CHECK,
        B_SEARCH,
        B_RESULT
    } back_state_t;

endpackage
`default_nettype wire

// ----- hdl/weighted_index_selection.sv -----
// Weighted random index selection: weight loads and roulette-wheel draws.
//
// Input words arrive on item_valid/item_stall/item_word. kind selects a load
// (write one weight, saturated to 1.0, at entry_index) or a draw (pick an
// index in proportion to its weight using random_word). A draw returns one
// word on result_valid/result_stall/result_word; a load returns nothing.
// cfg_wr_en/cfg_wr_data set entry_count; write it only while the block idles.
//
// A two-entry queue parts the input side from the execution side.
// Load: handled in the idle state of the execution side, so loads stream at one per cycle while no draw is in progress.
// Draw: a prefix sweep reads the weight store once per entry (N, the clamped
// entry count), then a multiply state scales random_word by the total, a
// check state tests index 0, and each bisection step reads the prefix store
// once (at most ceil(log2(N - 1)) steps, none when index 0 wins or N is 2).
// The result sits in an output register; while it is stalled, loads keep
// running and a following draw holds only at its final step.
// Reset clears control state and sets entry_count to the store depth; weight
// and prefix stores are not cleared, so every weight used must be loaded.
`default_nettype none
module weighted_index_selection #(
    parameter int MAX_ENTRIES          = 1024,
    parameter int WEIGHT_FRACTION_BITS = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [wis_pkg::COUNT_W-1:0] cfg_wr_data,
    input  wire logic                        item_valid,
    output logic                             item_stall,
    input  wire wis_pkg::in_word_t           item_word,
    output logic                             result_valid,
    input  wire logic                        result_stall,
    output wis_pkg::out_word_t               result_word
);
    import wis_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);

    q_item_t       push_item;
    q_item_t       pop_item;
    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_valid;
    logic [CW-1:0] count;

    wis_front #(
        .MAX_ENTRIES          (MAX_ENTRIES),
        .WEIGHT_FRACTION_BITS (WEIGHT_FRACTION_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item_word   (item_word),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (push_item),
        .count       (count)
    );

    wis_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .not_empty (q_valid)
    );

    wis_back #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (pop_item),
        .q_pop        (q_pop),
        .count        (count),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word)
    );

endmodule
`default_nettype wire

// ----- hdl/wis_front.sv -----
// Front end: count register, input handshake and word classification.
`default_nettype none
module wis_front #(
    parameter int MAX_ENTRIES          = 1024,
    parameter int WEIGHT_FRACTION_BITS = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [wis_pkg::COUNT_W-1:0]          cfg_wr_data,
    input  wire logic                                 item_valid,
    output logic                                      item_stall,
    input  wire wis_pkg::in_word_t                    item_word,
    input  wire logic                                 q_full,
    output logic                                      q_push,
    output wis_pkg::q_item_t                          q_item,
    output logic [$clog2(MAX_ENTRIES+1)-1:0]          count
);
    import wis_pkg::*;

    localparam int CW         = $clog2(MAX_ENTRIES + 1);
    localparam int CountLimit = (1 << COUNT_W) - 1;
    localparam int ResetCount = (MAX_ENTRIES > CountLimit) ? CountLimit : MAX_ENTRIES;
    localparam logic [31:0] WeightOne = 32'(1) << WEIGHT_FRACTION_BITS;

    logic [COUNT_W-1:0] entry_count_reg;
    logic [COUNT_W-1:0] entry_count_next;
    logic [31:0]        ec_ext;
    logic [31:0]        n_ext;
    logic [31:0]        w_ext;

    assign entry_count_next = cfg_wr_en ? cfg_wr_data : entry_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= COUNT_W'(ResetCount);
        end
        else
        begin
            entry_count_reg <= entry_count_next;
        end
    end

    // clamp count to [2, MAX_ENTRIES]
    assign ec_ext = 32'(entry_count_reg);
    always_comb
    begin
        if (ec_ext < 32'd2)
            n_ext = 32'd2;
        else if (ec_ext > 32'(MAX_ENTRIES))
            n_ext = 32'(MAX_ENTRIES);
        else
            n_ext = ec_ext;
    end
    assign count = n_ext[CW-1:0];

    assign item_stall = q_full;
    assign q_push     = item_valid && !q_full;
    assign w_ext      = 32'(item_word.weight);

    always_comb
    begin
        q_item.kind        = item_word.kind;
        q_item.load_ok     = (32'(item_word.entry_index) < 32'(MAX_ENTRIES));
        q_item.entry_index = item_word.entry_index;
        q_item.random_word = item_word.random_word;
        if (w_ext > WeightOne)
            q_item.weight = WeightOne[WEIGHT_W-1:0];
        else
            q_item.weight = item_word.weight;
    end

endmodule
`default_nettype wire

// ----- hdl/wis_queue.sv -----
// Two-entry queue between front and back end.
`default_nettype none
module wis_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire wis_pkg::q_item_t push_item,
    output logic                  full,
    input  wire logic             pop,
    output wis_pkg::q_item_t      pop_item,
    output logic                  not_empty
);
    import wis_pkg::*;

    q_item_t     slot_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  fill_reg;
    logic [1:0]  fill_next;
    logic        do_push;
    logic        do_pop;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule
`default_nettype wire

// ----- hdl/wis_back.sv -----
// Back end: weight store, prefix sweep, scaling, bisection and result register.
`default_nettype none
module wis_back #(
    parameter int MAX_ENTRIES = 1024
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              q_valid,
    input  wire wis_pkg::q_item_t                  q_item,
    output logic                                   q_pop,
    input  wire logic [$clog2(MAX_ENTRIES+1)-1:0]  count,
    output logic                                   result_valid,
    input  wire logic                              result_stall,
    output wis_pkg::out_word_t                     result_word
);
    import wis_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic [WEIGHT_W-1:0] wmem [MAX_ENTRIES];
    logic [SUM_W-1:0]    pmem [MAX_ENTRIES];
    logic [WEIGHT_W-1:0] w_rdata_reg;
    logic [SUM_W-1:0]    p_rdata_reg;

    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic                w_re;
    logic [AW-1:0]       w_raddr;
    logic                p_we;
    logic [AW-1:0]       p_waddr;
    logic [SUM_W-1:0]    p_wdata;
    logic                p_re;
    logic [AW-1:0]       p_raddr;

    back_state_t         state_reg, state_next;
    logic [CW-1:0]       issue_reg, issue_next;
    logic                rvld_reg, rvld_next;
    logic [AW-1:0]       ridx_reg, ridx_next;
    logic [SUM_W-1:0]    acc_reg, acc_next;
    logic [RANDOM_W-1:0] rnd_reg, rnd_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [AW-1:0]       lo_reg, lo_next;
    logic [AW-1:0]       hi_reg, hi_next;
    logic [AW-1:0]       mid_reg, mid_next;
    logic [AW-1:0]       res_reg, res_next;
    logic                out_valid_reg, out_valid_next;
    out_word_t           out_word_reg, out_word_next;
    logic                out_load;

    logic [31:0]         idx_ext;
    logic [31:0]         res_ext;
    logic [CW-1:0]       cnt_m1;
    logic [AW-1:0]       n_last;
    logic                sweep_last;
    logic [SUM_W:0]      sum_wide;
    logic [SUM_W-1:0]    acc_sat;
    logic [SUM_W-1:0]    target;
    logic                below_first;
    logic                span_wide;
    logic [AW-1:0]       mid_c;
    logic                go_right;
    logic [AW-1:0]       lo_s;
    logic [AW-1:0]       hi_s;
    logic [AW:0]         mid_sum;
    logic [AW-1:0]       mid_s;
    logic                span_s;
    logic                out_free;

    assign idx_ext    = 32'(q_item.entry_index);
    assign res_ext    = 32'(res_reg);
    assign cnt_m1     = count - CW'(1);
    assign n_last     = cnt_m1[AW-1:0];
    assign sweep_last = rvld_reg && (ridx_reg == n_last);

    assign sum_wide = {1'b0, acc_reg} + (SUM_W+1)'(w_rdata_reg);
    assign acc_sat  = (sum_wide > {1'b0, SUM_MAX}) ? SUM_MAX : sum_wide[SUM_W-1:0];

    assign target      = prod_reg[PROD_W-1:RANDOM_W];
    assign below_first = target < p_rdata_reg;
    assign span_wide   = n_last > AW'(1);
    assign mid_c       = n_last >> 1;

    assign go_right = target > p_rdata_reg;
    assign lo_s     = go_right ? mid_reg : lo_reg;
    assign hi_s     = go_right ? hi_reg : mid_reg;
    assign mid_sum  = {1'b0, lo_s} + {1'b0, hi_s};
    assign mid_s    = mid_sum[AW:1];
    assign span_s   = {1'b0, hi_s} > ({1'b0, lo_s} + (AW+1)'(1));

    assign out_free = !out_valid_reg || !result_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid && q_item.kind == KIND_DRAW)
                    state_next = B_SWEEP;
            end
            B_SWEEP:
            begin
                if (sweep_last)
                    state_next = B_MULT;
            end
            B_MULT:
            begin
                state_next = B_CHECK;
            end
            B_CHECK:
            begin
                if (below_first || !span_wide)
                    state_next = B_RESULT;
                else
                    state_next = B_SEARCH;
            end
            B_SEARCH:
            begin
                if (!span_s)
                    state_next = B_RESULT;
            end
            B_RESULT:
            begin
                if (out_free)
                    state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        q_pop      = 1'b0;
        w_we       = 1'b0;
        w_waddr    = idx_ext[AW-1:0];
        w_re       = 1'b0;
        w_raddr    = issue_reg[AW-1:0];
        p_we       = 1'b0;
        p_waddr    = ridx_reg;
        p_wdata    = acc_sat;
        p_re       = 1'b0;
        p_raddr    = '0;
        issue_next = issue_reg;
        rvld_next  = 1'b0;
        ridx_next  = ridx_reg;
        acc_next   = acc_reg;
        rnd_next   = rnd_reg;
        prod_next  = prod_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        res_next   = res_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                q_pop = q_valid;
                if (q_valid)
                begin
                    if (q_item.kind == KIND_LOAD)
                    begin
                        w_we = q_item.load_ok;
                    end
                    else
                    begin
                        rnd_next   = q_item.random_word;
                        acc_next   = '0;
                        issue_next = '0;
                    end
                end
            end
            B_SWEEP:
            begin
                if (issue_reg < count)
                begin
                    w_re       = 1'b1;
                    issue_next = issue_reg + CW'(1);
                    rvld_next  = 1'b1;
                    ridx_next  = issue_reg[AW-1:0];
                end
                if (rvld_reg)
                begin
                    acc_next = acc_sat;
                    p_we     = 1'b1;
                end
            end
            B_MULT:
            begin
                prod_next = PROD_W'(rnd_reg) * PROD_W'(acc_reg);
                p_re      = 1'b1;
            end
            B_CHECK:
            begin
                if (below_first)
                begin
                    res_next = '0;
                end
                else if (span_wide)
                begin
                    lo_next  = '0;
                    hi_next  = n_last;
                    mid_next = mid_c;
                    p_re     = 1'b1;
                    p_raddr  = mid_c;
                end
                else
                begin
                    res_next = n_last;
                end
            end
            B_SEARCH:
            begin
                lo_next = lo_s;
                hi_next = hi_s;
                if (span_s)
                begin
                    mid_next = mid_s;
                    p_re     = 1'b1;
                    p_raddr  = mid_s;
                end
                else
                begin
                    res_next = hi_s;
                end
            end
            B_RESULT:
            begin
                out_load = out_free;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_load || (out_valid_reg && result_stall);
        out_word_next  = out_word_reg;
        if (out_load)
        begin
            out_word_next.chosen_index = res_ext[INDEX_W-1:0];
            out_word_next.total_weight = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            rvld_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rvld_reg      <= rvld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_reg    <= issue_next;
        ridx_reg     <= ridx_next;
        acc_reg      <= acc_next;
        rnd_reg      <= rnd_next;
        prod_reg     <= prod_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        res_reg      <= res_next;
        out_word_reg <= out_word_next;
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
            wmem[w_waddr] <= q_item.weight;
        if (w_re)
            w_rdata_reg <= wmem[w_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
            pmem[p_waddr] <= p_wdata;
        if (p_re)
            p_rdata_reg <= pmem[p_raddr];
    end

    assign result_valid = out_valid_reg;
    assign result_word  = out_word_reg;

endmodule
`default_nettype wire

// ----- hdl/wis_checker.sv -----
// Port-level checks for the weighted index selection block, with its bind.
`default_nettype none
module wis_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               item_valid,
    input wire logic               item_stall,
    input wire wis_pkg::in_word_t  item_word,
    input wire logic               result_valid,
    input wire logic               result_stall,
    input wire wis_pkg::out_word_t result_word
);
    import wis_pkg::*;

    logic [2:0] pending_reg;
    logic [2:0] pending_next;
    logic       draw_in;
    logic       word_out;

    assign draw_in  = item_valid && !item_stall && item_word.kind == KIND_DRAW;
    assign word_out = result_valid && !result_stall;

    always_comb
    begin
        pending_next = pending_reg + 3'(draw_in) - 3'(word_out);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= 3'd0;
        else
            pending_reg <= pending_next;
    end

    // stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_word))
        else $error("result word changed while stalled");

    // every result belongs to an accepted draw
    a_result_owed: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pending_reg != 3'd0)
        else $error("result without an outstanding draw");

    // all-zero weights select index one
    a_zero_total: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_word.total_weight == '0 |->
            result_word.chosen_index == INDEX_W'(1))
        else $error("zero total did not select index one");

endmodule

bind weighted_index_selection wis_checker u_wis_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item_word    (item_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word)
);
`default_nettype wire

// ----- test/tb_weighted_index_selection.sv -----
// Testbench for weighted_index_selection: random loads and draws checked against a predictor.
`default_nettype none
module tb_weighted_index_selection;
    import wis_pkg::*;

    localparam int unsigned STORE_DEPTH = 1024;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

    class selection_scoreboard;
        logic [WEIGHT_W-1:0] weights [STORE_DEPTH];
        logic [SUM_W-1:0]    running_sum [STORE_DEPTH];
        int unsigned         count_reg;
        out_word_t           expected_q [$];
        int unsigned         mismatches;
        int unsigned         strays;
        int unsigned         reports;

        function new();
            count_reg  = STORE_DEPTH;
            mismatches = 0;
            strays     = 0;
            reports    = 0;
        endfunction

        function void set_count(logic [COUNT_W-1:0] value);
            count_reg = 32'(value);
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void note_word(in_word_t w);
            int unsigned n;
            int unsigned i;
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            logic [63:0] acc;
            logic [63:0] target;
            out_word_t   pick;
            if (w.kind == KIND_LOAD)
            begin
                weights[w.entry_index] = (w.weight > WEIGHT_ONE) ? WEIGHT_ONE : w.weight;
                return;
            end
            n = count_reg;
            if (n < 2) n = 2;
            if (n > STORE_DEPTH) n = STORE_DEPTH;
            acc = '0;
            for (i = 0; i < n; i++)
            begin
                acc = acc + weights[i];
                if (acc > SUM_MAX) acc = SUM_MAX;
                running_sum[i] = acc[SUM_W-1:0];
            end
            target = ({32'b0, w.random_word} * acc) >> 32;
            if (target < running_sum[0])
            begin
                hi = 0;
            end
            else
            begin
                lo = 0;
                hi = n - 1;
                while (hi - lo > 1)
                begin
                    mid = (lo + hi) >> 1;
                    if (target > running_sum[mid]) lo = mid;
                    else hi = mid;
                end
            end
            pick.chosen_index = hi[INDEX_W-1:0];
            pick.total_weight = acc[SUM_W-1:0];
            expected_q.push_back(pick);
        endfunction

        function void check_result(out_word_t got);
            out_word_t want;
            if (expected_q.size() == 0)
            begin
                strays++;
                if (reports < 10)
                    $display("unexpected result: index %0d total %0d",
                             got.chosen_index, got.total_weight);
                reports++;
                return;
            end
            want = expected_q.pop_front();
            if (got.chosen_index !== want.chosen_index ||
                got.total_weight !== want.total_weight)
            begin
                mismatches++;
                if (reports < 10)
                    $display("mismatch: index exp %0d got %0d, total exp %0d got %0d",
                             want.chosen_index, got.chosen_index,
                             want.total_weight, got.total_weight);
                reports++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [COUNT_W-1:0]   cfg_wr_data;
    logic                 item_valid;
    logic                 item_stall;
    in_word_t             item_word;
    logic                 result_valid;
    logic                 result_stall;
    out_word_t            result_word;

    selection_scoreboard sb = new();
    bit                  quiet;
    bit                  hold_req;
    int unsigned         phase_counts [11];

    weighted_index_selection dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_word    (item_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #15_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [WEIGHT_W-1:0] rand_weight();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 20) return '0;
        if (r < 30) return WEIGHT_ONE;
        if (r < 40) return WEIGHT_W'($urandom_range(65537, 131071));
        if (r < 55) return WEIGHT_W'($urandom_range(1, 16));
        return WEIGHT_W'($urandom_range(0, 65536));
    endfunction

    function automatic logic [RANDOM_W-1:0] rand_fraction();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 20) return '1;
        return $urandom;
    endfunction

    function automatic in_word_t load_word(int unsigned idx, logic [WEIGHT_W-1:0] w);
        in_word_t word;
        word.kind        = KIND_LOAD;
        word.entry_index = idx[INDEX_W-1:0];
        word.weight      = w;
        word.random_word = $urandom;
        return word;
    endfunction

    function automatic in_word_t draw_word(logic [RANDOM_W-1:0] fraction);
        in_word_t word;
        word.kind        = KIND_DRAW;
        word.entry_index = INDEX_W'($urandom);
        word.weight      = WEIGHT_W'($urandom);
        word.random_word = fraction;
        return word;
    endfunction

    function automatic in_word_t random_word_item(int unsigned active);
        int unsigned idx;
        if ($urandom_range(0, 99) < 40) return draw_word(rand_fraction());
        if ($urandom_range(0, 99) < 70) idx = $urandom_range(0, active - 1);
        else idx = $urandom_range(0, STORE_DEPTH - 1);
        return load_word(idx, rand_weight());
    endfunction

    task automatic send_word(in_word_t w);
        int unsigned gap;
        @(negedge clk);
        item_valid <= 1'b1;
        item_word  <= w;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        sb.note_word(w);
        gap = (quiet || $urandom_range(0, 99) < 60) ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        item_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        // queued loads may still be in flight
        repeat (16) @(posedge clk);
    endtask

    task automatic set_count(logic [COUNT_W-1:0] value);
        drain();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_count(value);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result_word);
    end

    initial
    begin
        int unsigned hold_left;
        int unsigned stall_left;
        bit          hold_seen;
        result_stall = 1'b0;
        hold_left    = 0;
        stall_left   = 0;
        hold_seen    = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_seen && hold_left == 0)
            begin
                hold_left = 400;
                hold_seen = 1'b1;
            end
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                result_stall <= 1'b0;
                if (!quiet && $urandom_range(0, 99) < 15) stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        int unsigned i;
        int unsigned p;
        int unsigned active;
        int unsigned items;
        int unsigned failures;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        item_valid  = 1'b0;
        item_word   = '0;
        quiet       = 1'b0;
        hold_req    = 1'b0;
        phase_counts = '{2, 5, 17, 1, 64, 33, 8, 2047, 40, 3, 1024};
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // fill the whole store, then draw with the reset entry count
        for (i = 0; i < STORE_DEPTH; i++)
            send_word(load_word(i, rand_weight()));
        send_word(draw_word('0));
        send_word(draw_word('1));
        send_word(draw_word($urandom));

        // all weights zero, count below range
        set_count('0);
        send_word(load_word(0, '0));
        send_word(load_word(1, '0));
        send_word(draw_word('1));
        send_word(draw_word('0));
        // weights above one saturate
        send_word(load_word(0, 17'h1FFFF));
        send_word(load_word(1, 17'h10001));
        send_word(draw_word('0));
        send_word(draw_word('1));
        send_word(load_word(0, WEIGHT_ONE));
        send_word(load_word(1, 17'd1));
        send_word(draw_word(32'hFFFF0000));
        set_count(11'd1);
        send_word(draw_word($urandom));
        set_count(11'd3);
        send_word(load_word(2, 17'd12345));
        send_word(draw_word(32'h80000000));
        send_word(draw_word(32'h00000001));

        for (p = 0; p < 11; p++)
        begin
            set_count(phase_counts[p][COUNT_W-1:0]);
            active = phase_counts[p];
            if (active < 2) active = 2;
            if (active > STORE_DEPTH) active = STORE_DEPTH;
            quiet = (p == 6);
            if (p == 1) hold_req = 1'b1;
            items = (active >= 512) ? 30 : 60;
            for (i = 0; i < items; i++)
                send_word(random_word_item(active));
        end
        quiet = 1'b0;

        drain();
        repeat (1100) @(posedge clk);
        failures = sb.mismatches + sb.strays + sb.pending();
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire

// ----- files.f -----
hdl/wis_pkg.sv
hdl/wis_front.sv
hdl/wis_queue.sv
hdl/wis_back.sv
hdl/weighted_index_selection.sv
hdl/wis_checker.sv
test/tb_weighted_index_selection.sv
